/* rtl/nir_pkg.sv */
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Shared widths, register map, status codes and the pulse match flags.
// ----------------------------------------------------------------------------
package nir_pkg;

    localparam int DUR_W    = 16;
    localparam int CFG_W    = 12;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;
    localparam int FRAME_W  = 32;
    localparam int CNT_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_W - 1);

    localparam logic [CFG_W-1:0] UNIT_RESET   = CFG_W'(563);
    localparam logic [CFG_W-1:0] MARGIN_RESET = CFG_W'(281);

    localparam logic [APB_AW-3:0] REG_UNIT   = 1'b0;
    localparam logic [APB_AW-3:0] REG_MARGIN = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DATA   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REPEAT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] unit_us;
        logic [CFG_W-1:0] margin_us;
    } cfg_t;

    typedef struct packed {
        logic m16;
        logic m8;
        logic m4;
        logic m3;
        logic m1;
    } match_t;

endpackage

/* rtl/nir_ifs.sv */
// ----------------------------------------------------------------------------
// NEC IR frame decoder channel interfaces
// Pulse event channel and decoded frame channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nir_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic                          pulse_level;
    logic [nir_pkg::DUR_W-1:0]     pulse_duration;

    modport source (output valid, output req_type, output pulse_level,
                    output pulse_duration, input ready);
    modport sink   (input valid, input req_type, input pulse_level,
                    input pulse_duration, output ready);
endinterface

interface nir_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nir_pkg::STATUS_W-1:0]  status;
    logic [nir_pkg::BYTE_W-1:0]    address;
    logic [nir_pkg::BYTE_W-1:0]    command;

    modport source (output valid, output status, output address,
                    output command, input ready);
    modport sink   (input valid, input status, input address,
                    input command, output ready);
endinterface

/* rtl/nir_cfg_regs.sv */
// ----------------------------------------------------------------------------
// NEC IR configuration registers
// APB register file holding the pulse unit and the match margin.
// ----------------------------------------------------------------------------
module nir_cfg_regs import nir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CFG_W-1:0]  unit_reg;
    logic [CFG_W-1:0]  margin_reg;
    logic              wr_en;
    logic [APB_AW-3:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg   <= UNIT_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_UNIT:   unit_reg   <= pwdata[CFG_W-1:0];
                REG_MARGIN: margin_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_UNIT:   prdata = APB_DW'(unit_reg);
            REG_MARGIN: prdata = APB_DW'(margin_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.unit_us   = unit_reg;
    assign cfg.margin_us = margin_reg;

endmodule

/* rtl/nir_classify.sv */
// ----------------------------------------------------------------------------
// NEC IR pulse classifier
// Compares a pulse duration against the nominal unit multiples of a frame.
// ----------------------------------------------------------------------------
module nir_classify import nir_pkg::*;
(
    input  cfg_t             cfg,
    input  logic [DUR_W-1:0] duration,
    output match_t           match
);

    function automatic logic near(input logic [DUR_W-1:0] dur,
                                  input logic [DUR_W-1:0] nominal,
                                  input logic [CFG_W-1:0] margin);
        logic [DUR_W:0] dur_hi;
        logic [DUR_W:0] nom_hi;
        dur_hi = {1'b0, dur} + (DUR_W+1)'(margin);
        nom_hi = {1'b0, nominal} + (DUR_W+1)'(margin);
        return (dur_hi > {1'b0, nominal}) && ({1'b0, dur} < nom_hi);
    endfunction

    logic [DUR_W-1:0] nom1;
    logic [DUR_W-1:0] nom3;
    logic [DUR_W-1:0] nom4;
    logic [DUR_W-1:0] nom8;
    logic [DUR_W-1:0] nom16;

    assign nom1  = DUR_W'(cfg.unit_us);
    assign nom3  = (nom1 << 1) + nom1;
    assign nom4  = nom1 << 2;
    assign nom8  = nom1 << 3;
    assign nom16 = nom1 << 4;

    assign match.m1  = near(duration, nom1,  cfg.margin_us);
    assign match.m3  = near(duration, nom3,  cfg.margin_us);
    assign match.m4  = near(duration, nom4,  cfg.margin_us);
    assign match.m8  = near(duration, nom8,  cfg.margin_us);
    assign match.m16 = near(duration, nom16, cfg.margin_us);

endmodule

/* rtl/nir_frame_fsm.sv */
// ----------------------------------------------------------------------------
// NEC IR frame state machine
// Input word register, frame sequencer and registered result word.
// ----------------------------------------------------------------------------
module nir_frame_fsm import nir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    nir_req_if.sink          req,
    nir_rsp_if.source        rsp,
    input  match_t           match,
    output logic [DUR_W-1:0] duration
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEAD_HI = 2'd1;
    localparam logic [1:0] PH_BIT_LO  = 2'd2;
    localparam logic [1:0] PH_BIT_HI  = 2'd3;

    logic                s1_valid_reg;
    logic                s1_timeout_reg;
    logic                s1_level_reg;
    logic [DUR_W-1:0]    s1_dur_reg;

    logic [1:0]          phase_reg,  phase_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [FRAME_W-1:0]  frame_reg,  frame_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   addr_reg,   addr_next;
    logic [BYTE_W-1:0]   cmd_reg,    cmd_next;

    logic                advance;
    logic                emit;
    logic                bit_val;
    logic [FRAME_W-1:0]  shifted;

    assign advance  = s1_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready = ~s1_valid_reg | advance;
    assign duration = s1_dur_reg;
    assign bit_val  = match.m3;
    assign shifted  = {bit_val, frame_reg[FRAME_W-1:1]};

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        frame_next  = frame_reg;
        emit        = 1'b0;
        status_next = ST_ERROR;
        addr_next   = '0;
        cmd_next    = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!s1_timeout_reg)
                begin
                    if (!s1_level_reg && match.m16)
                        phase_next = PH_HEAD_HI;
                    else
                        emit = 1'b1;
                end
            end
            PH_HEAD_HI:
            begin
                phase_next = PH_IDLE;
                if (!s1_timeout_reg)
                begin
                    if (s1_level_reg && match.m8)
                    begin
                        phase_next = PH_BIT_LO;
                        cnt_next   = '0;
                        frame_next = '0;
                    end
                    else if (s1_level_reg && match.m4)
                    begin
                        emit        = 1'b1;
                        status_next = ST_REPEAT;
                    end
                    else
                        emit = 1'b1;
                end
            end
            PH_BIT_LO:
            begin
                if (!s1_timeout_reg && !s1_level_reg && match.m1)
                    phase_next = PH_BIT_HI;
                else
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                end
            end
            PH_BIT_HI:
            begin
                if (s1_timeout_reg || !s1_level_reg || !(match.m3 || match.m1))
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                end
                else
                begin
                    frame_next = shifted;
                    cnt_next   = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_BIT)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        if (shifted[23:16] == ~shifted[31:24])
                        begin
                            status_next = ST_DATA;
                            addr_next   = shifted[7:0];
                            cmd_next    = shifted[23:16];
                        end
                    end
                    else
                        phase_next = PH_BIT_LO;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (advance)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                frame_reg     <= frame_next;
                out_valid_reg <= emit;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_timeout_reg <= req.req_type;
            s1_level_reg   <= req.pulse_level;
            s1_dur_reg     <= req.pulse_duration;
        end
        if (advance && emit)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.address = addr_reg;
    assign rsp.command = cmd_reg;

    a_last_bit_emits: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_BIT_HI && cnt_reg == LAST_BIT |=> out_valid_reg)
        else $error("final bit of a frame produced no result word");

    a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |=> phase_reg == PH_IDLE || phase_reg == PH_HEAD_HI)
        else $error("idle left for a phase other than the header high");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEAD_HI ##1 phase_reg == PH_BIT_LO |-> cnt_reg == '0)
        else $error("bit counter not cleared at frame start");

    a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_DATA |-> addr_reg == '0 && cmd_reg == '0)
        else $error("non-data result carries address or command");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> status_reg == ST_DATA || status_reg == ST_REPEAT ||
                          status_reg == ST_ERROR)
        else $error("result status outside the defined codes");

endmodule

/* rtl/nec_ir_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// NEC IR frame decoder core
// Decodes NEC remote frames from timed pulse events.
// ----------------------------------------------------------------------------
// The req channel carries one word per pulse event: its polarity and length
// in microseconds, or a timeout marker. The rsp channel returns at most one
// word per event: a data frame with address and command, a repeat code, or
// an error. Both channels use a valid/ready handshake.
// An accepted event is held in an input register; it is then classified
// against the unit multiples and written into the result register once
// that register is free. One event is accepted every cycle as long as the
// result register is empty or being read in the same cycle. When the
// receiver stalls with a result pending, one more event is taken into the
// input register and then req.ready drops until rsp is read. The APB port
// sets the pulse unit (offset 0) and the margin (offset 4); reset loads 563
// and 281, empties both registers and returns to idle.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core import nir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    nir_req_if.sink           req,
    nir_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t             cfg;
    match_t           match;
    logic [DUR_W-1:0] duration;

    nir_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nir_classify u_classify (
        .cfg      (cfg),
        .duration (duration),
        .match    (match)
    );

    nir_frame_fsm u_frame_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .match    (match),
        .duration (duration)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Feeds timed pulse events into the decoder, first from a short table of
// header, repeat, boundary and error cases, then as random phases of mostly
// well-formed frames with broken frames and noise mixed in. Each phase runs
// under its own pulse unit and margin, set over APB while the decoder is
// idle. Every decoded word is checked against a predictor kept in this file.
// ----------------------------------------------------------------------------
module testbench;
    import nir_pkg::*;

    localparam logic EV_PULSE   = 1'b0;
    localparam logic EV_TIMEOUT = 1'b1;
    localparam logic LVL_LOW    = 1'b0;
    localparam logic LVL_HIGH   = 1'b1;
    localparam logic TYPED      = 1'b1;
    localparam logic PREDICTED  = 1'b0;
    localparam logic HAS_RSP    = 1'b1;
    localparam logic NO_RSP     = 1'b0;

    localparam int PHASES        = 8;
    localparam int PHASE_EVENTS  = 180;
    localparam int IDLE_PCT      = 21;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [1:0] {
        AWAIT_HEADER_LO,
        AWAIT_HEADER_HI,
        AWAIT_BIT_LO,
        AWAIT_BIT_HI
    } dec_phase_t;

    typedef struct packed {
        logic             rtype;
        logic             lvl;
        logic [DUR_W-1:0] dur;
    } pulse_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   address;
        logic [BYTE_W-1:0]   command;
    } frame_t;

    typedef struct packed {
        logic                rtype;
        logic                lvl;
        logic [DUR_W-1:0]    dur;
        logic                typed;
        logic                has;
        logic [STATUS_W-1:0] status;
    } step_row_t;

    // Durations assume the reset unit of 563 us and margin of 281 us.
    localparam step_row_t DIRECTED_ROWS [25] = '{
        '{EV_TIMEOUT, LVL_LOW,  16'd0,     TYPED,     NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd65535, TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd0,     TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd8727,  TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd9289,  TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd8728,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_TIMEOUT, LVL_HIGH, 16'd65535, TYPED,     NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_LOW,  16'd9288,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd2252,  TYPED,     HAS_RSP, ST_REPEAT},
        '{EV_PULSE,   LVL_LOW,  16'd9008,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_LOW,  16'd4504,  TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd9008,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd4504,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_TIMEOUT, LVL_LOW,  16'd0,     TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd9008,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd4784,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd563,   TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd9008,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd4224,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_LOW,  16'd563,   PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd3000,  TYPED,     HAS_RSP, ST_ERROR},
        '{EV_PULSE,   LVL_LOW,  16'd9008,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_HIGH, 16'd4504,  PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_LOW,  16'd283,   PREDICTED, NO_RSP,  ST_DATA},
        '{EV_PULSE,   LVL_LOW,  16'd1689,  TYPED,     HAS_RSP, ST_ERROR}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    nir_req_if req_ch ();
    nir_rsp_if rsp_ch ();

    nec_ir_frame_decoder_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cfg_t             dec_cfg;
    dec_phase_t       dec_phase;
    logic [5:0]       bits_seen;
    logic [FRAME_W-1:0] frame_word;

    frame_t decoded_q [$];
    frame_t want_frame;
    int     mismatches;
    int     phase_events;
    bit     calm;
    bit     stall;
    bit     pressure_go;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < 50)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic bit in_window(input logic [DUR_W-1:0] dur, input int units);
        int nominal;
        nominal = units * int'(dec_cfg.unit_us);
        return (int'(dur) + int'(dec_cfg.margin_us) > nominal)
            && (int'(dur) < nominal + int'(dec_cfg.margin_us));
    endfunction

    task automatic decode_pulse(input pulse_t ev, output bit emits, output frame_t res);
        bit bad;
        bad   = 1'b0;
        emits = 1'b0;
        res   = '0;
        case (dec_phase)
            AWAIT_HEADER_LO:
            begin
                if (ev.rtype == EV_PULSE)
                begin
                    if (ev.lvl == LVL_LOW && in_window(ev.dur, 16))
                        dec_phase = AWAIT_HEADER_HI;
                    else
                        bad = 1'b1;
                end
            end
            AWAIT_HEADER_HI:
            begin
                if (ev.rtype == EV_TIMEOUT)
                    dec_phase = AWAIT_HEADER_LO;
                else if (ev.lvl == LVL_HIGH && in_window(ev.dur, 8))
                begin
                    dec_phase  = AWAIT_BIT_LO;
                    bits_seen  = '0;
                    frame_word = '0;
                end
                else if (ev.lvl == LVL_HIGH && in_window(ev.dur, 4))
                begin
                    dec_phase  = AWAIT_HEADER_LO;
                    emits      = 1'b1;
                    res.status = ST_REPEAT;
                end
                else
                    bad = 1'b1;
            end
            AWAIT_BIT_LO:
            begin
                if (ev.rtype == EV_TIMEOUT || ev.lvl != LVL_LOW || !in_window(ev.dur, 1))
                    bad = 1'b1;
                else
                    dec_phase = AWAIT_BIT_HI;
            end
            default:
            begin
                if (ev.rtype == EV_TIMEOUT || ev.lvl != LVL_HIGH)
                    bad = 1'b1;
                else if (!in_window(ev.dur, 3) && !in_window(ev.dur, 1))
                    bad = 1'b1;
                else
                begin
                    // The long bit window is tested first where the two overlap.
                    if (in_window(ev.dur, 3))
                        frame_word[bits_seen[4:0]] = 1'b1;
                    bits_seen = bits_seen + 6'd1;
                    if (bits_seen < 6'(FRAME_W))
                        dec_phase = AWAIT_BIT_LO;
                    else
                    begin
                        dec_phase = AWAIT_HEADER_LO;
                        emits     = 1'b1;
                        if (frame_word[23:16] != ~frame_word[31:24])
                            res.status = ST_ERROR;
                        else
                        begin
                            res.status  = ST_DATA;
                            res.address = frame_word[7:0];
                            res.command = frame_word[23:16];
                        end
                    end
                end
            end
        endcase
        if (bad)
        begin
            dec_phase  = AWAIT_HEADER_LO;
            emits      = 1'b1;
            res.status = ST_ERROR;
        end
    endtask

    task automatic offer_pulse(input pulse_t ev, input logic typed, input logic typed_has,
                               input frame_t typed_res);
        bit     emits;
        frame_t res;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= ev.rtype;
        req_ch.pulse_level    <= ev.lvl;
        req_ch.pulse_duration <= ev.dur;
        do
            @(posedge clk);
        while (!req_ch.ready);
        decode_pulse(ev, emits, res);
        if (typed)
        begin
            emits = typed_has;
            res   = typed_res;
        end
        if (emits)
            decoded_q.push_back(res);
        phase_events++;
    endtask

    function automatic pulse_t shaped_pulse(input logic lvl, input int units);
        int     dev;
        int     dur;
        pulse_t p;
        dev = 0;
        if (dec_cfg.margin_us != '0)
            dev = int'($urandom_range(int'(dec_cfg.margin_us) - 1));
        if ($urandom_range(39) == 0)
            dev = int'(dec_cfg.margin_us);
        if ($urandom_range(1) == 1)
            dev = -dev;
        dur = units * int'(dec_cfg.unit_us) + dev;
        if (dur < 0)
            dur = 0;
        if (dur > 65535)
            dur = 65535;
        p.rtype = EV_PULSE;
        p.lvl   = lvl;
        p.dur   = DUR_W'(dur);
        return p;
    endfunction

    function automatic pulse_t noise_pulse();
        pulse_t p;
        int     units;
        case ($urandom_range(4))
            0: units = 1;
            1: units = 3;
            2: units = 4;
            3: units = 8;
            default: units = 16;
        endcase
        if ($urandom_range(1) == 1)
            p = shaped_pulse(1'($urandom_range(1)), units);
        else
        begin
            p.rtype = EV_PULSE;
            p.lvl   = 1'($urandom_range(1));
            p.dur   = DUR_W'($urandom_range(65535));
        end
        if ($urandom_range(4) == 0)
            p.rtype = EV_TIMEOUT;
        return p;
    endfunction

    task automatic send_sequence();
        pulse_t       seq [$];
        pulse_t       p;
        int           kind;
        int           cut;
        logic [31:0]  word;
        kind = $urandom_range(99);
        if (kind < 80)
            seq.push_back(shaped_pulse(LVL_LOW, 16));
        if (kind < 50)
        begin
            word = $urandom;
            if ($urandom_range(3) != 0)
                word[31:24] = ~word[23:16];
            seq.push_back(shaped_pulse(LVL_HIGH, 8));
            for (int i = 0; i < FRAME_W; i++)
            begin
                seq.push_back(shaped_pulse(LVL_LOW, 1));
                seq.push_back(shaped_pulse(LVL_HIGH, word[i] ? 3 : 1));
            end
        end
        else if (kind < 65)
            seq.push_back(shaped_pulse(LVL_HIGH, 4));
        else if (kind < 80)
        begin
            p.rtype = EV_TIMEOUT;
            p.lvl   = 1'($urandom_range(1));
            p.dur   = DUR_W'($urandom_range(65535));
            seq.push_back(p);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                seq.push_back(noise_pulse());
        end
        cut = ($urandom_range(6) == 0) ? int'($urandom_range(seq.size() - 1)) : -1;
        for (int i = 0; i < seq.size(); i++)
        begin
            if (i == cut)
            begin
                offer_pulse(noise_pulse(), PREDICTED, NO_RSP, '0);
                break;
            end
            offer_pulse(seq[i], PREDICTED, NO_RSP, '0);
        end
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_AW-1:0] addr,
                                input logic [CFG_W-1:0] value, output logic [APB_DW-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= {20'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr && addr == APB_AW'({REG_UNIT, 2'b00}))
            dec_cfg.unit_us = value;
        else if (wr)
            dec_cfg.margin_us = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_register(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] rdata;
        apb_transfer(1'b1, addr, value, rdata);
        apb_transfer(1'b0, addr, '0, rdata);
        if (rdata[CFG_W-1:0] !== value)
            flag_mismatch($sformatf("register at %0d reads %0d, wrote %0d",
                                    addr, rdata[CFG_W-1:0], value));
    endtask

    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (decoded_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= !stall && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        stall = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        stall = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (decoded_q.size() == 0)
                flag_mismatch($sformatf("unexpected word status %0d", rsp_ch.status));
            else
            begin
                want_frame = decoded_q.pop_front();
                if (rsp_ch.status !== want_frame.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, want_frame.status));
                if (rsp_ch.address !== want_frame.address)
                    flag_mismatch($sformatf("address %0h, expected %0h",
                                            rsp_ch.address, want_frame.address));
                if (rsp_ch.command !== want_frame.command)
                    flag_mismatch($sformatf("command %0h, expected %0h",
                                            rsp_ch.command, want_frame.command));
            end
        end
    end

    initial
    begin
        cfg_t   phase_cfg [PHASES];
        frame_t row_res;
        pulse_t row_ev;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = EV_PULSE;
        req_ch.pulse_level    = LVL_LOW;
        req_ch.pulse_duration = '0;
        rsp_ch.ready          = 1'b0;
        mismatches            = 0;
        phase_events          = 0;
        calm                  = 1'b0;
        pressure_go           = 1'b0;
        dec_cfg.unit_us       = UNIT_RESET;
        dec_cfg.margin_us     = MARGIN_RESET;
        dec_phase             = AWAIT_HEADER_LO;
        bits_seen             = '0;
        frame_word            = '0;

        phase_cfg[0] = '{unit_us: 12'd563,  margin_us: 12'd281};
        phase_cfg[1] = '{unit_us: 12'd1,    margin_us: 12'd0};
        phase_cfg[2] = '{unit_us: 12'd4095, margin_us: 12'd4095};
        phase_cfg[3] = '{unit_us: 12'd4095, margin_us: 12'd1};
        phase_cfg[4] = '{unit_us: 12'd100,  margin_us: 12'd150};
        phase_cfg[5] = '{unit_us: 12'd1,    margin_us: 12'd4095};
        for (int i = 6; i < PHASES; i++)
        begin
            phase_cfg[i].unit_us   = CFG_W'($urandom_range(1, 4095));
            phase_cfg[i].margin_us = CFG_W'($urandom_range(0, int'(phase_cfg[i].unit_us)));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            row_ev.rtype   = DIRECTED_ROWS[i].rtype;
            row_ev.lvl     = DIRECTED_ROWS[i].lvl;
            row_ev.dur     = DIRECTED_ROWS[i].dur;
            row_res        = '0;
            row_res.status = DIRECTED_ROWS[i].status;
            offer_pulse(row_ev, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has, row_res);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            calm = (ph == 5);
            if (ph == 0)
                pressure_go = 1'b1;
            set_register(APB_AW'({REG_UNIT, 2'b00}), phase_cfg[ph].unit_us);
            set_register(APB_AW'({REG_MARGIN, 2'b00}), phase_cfg[ph].margin_us);
            phase_events = 0;
            while (phase_events < PHASE_EVENTS)
                send_sequence();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/nir_pkg.sv
rtl/nir_ifs.sv
rtl/nir_cfg_regs.sv
rtl/nir_classify.sv
rtl/nir_frame_fsm.sv
rtl/nec_ir_frame_decoder_core.sv
bench/testbench.sv
